// ===== design/upmx_pkg.sv =====
// Shared types and constants for the uniform PMX crossover block.
// Used by upmx_ctrl, upmx_dp and uniform_pmx_crossover; depends on nothing.
package upmx_pkg;

  localparam int SLOT_W     = 6;
  localparam int SLOTS      = 64;
  localparam int CNT_W      = 7;
  localparam int ATT_W      = 5;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [CNT_W-1:0] PERM_LEN_RST = 7'd64;

  // Division by three as a multiply by 43 and a shift by 7, exact below 128.
  localparam int DIV3_MUL   = 43;
  localparam int DIV3_SHIFT = 7;

  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ATTEMPT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_DRAW    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUST = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd3;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_D0,
    OP_D1,
    OP_D2,
    OP_D3,
    OP_C0,
    OP_C1,
    OP_C2,
    OP_C3,
    OP_C4
  } upmx_op_e;

  typedef struct packed {
    upmx_op_e op;
    logic     emit;
  } upmx_cmd_t;

  typedef struct packed {
    logic go_attempt;
    logic redrop;
  } upmx_sts_t;

endpackage

// ===== design/uniform_pmx_crossover.sv =====
// Uniform PMX crossover. A load, read or rejected request passes only through
// the capture step and the done state; an accepted attempt also runs the list
// removal steps D0-D3 and the child swap steps C0-C4, repeating D0-D3 when the
// second position must also leave the legal list. One request at a time: the
// next transfer in is taken only once the previous result has been emitted.
// Reset clears the legal and attempt counts and sets the length to 64; the
// position memories are not cleared and must be loaded before use.
module uniform_pmx_crossover #(
  parameter int MAX_LEN = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [upmx_pkg::CNT_W-1:0]      cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // position, parent1_value, parent2_value, random_draw
  input  logic [upmx_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // req_type
  input  logic [upmx_pkg::REQ_W-1:0]      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // child_value, legal_left, attempts_left, zero fill
  output logic [upmx_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [upmx_pkg::STAT_W-1:0]     m_axis_tuser_o
);
  import upmx_pkg::*;

  upmx_cmd_t         cmd;
  upmx_sts_t         sts;
  logic [SLOT_W-1:0] child_value;
  logic [CNT_W-1:0]  legal_left;
  logic [ATT_W-1:0]  attempts_left;

  upmx_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  upmx_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (s_axis_tuser_i),
    .position_i      (s_axis_tdata_i[SLOT_W-1:0]),
    .parent1_value_i (s_axis_tdata_i[2*SLOT_W-1:SLOT_W]),
    .parent2_value_i (s_axis_tdata_i[3*SLOT_W-1:2*SLOT_W]),
    .random_draw_i   (s_axis_tdata_i[4*SLOT_W-1:3*SLOT_W]),
    .status_o        (m_axis_tuser_o),
    .child_value_o   (child_value),
    .legal_left_o    (legal_left),
    .attempts_left_o (attempts_left)
  );

  assign m_axis_tdata_o = {(OUT_DATA_W - SLOT_W - CNT_W - ATT_W)'(0),
                           attempts_left, legal_left, child_value};

  localparam logic [CNT_W-1:0] MaxLenC = CNT_W'(MAX_LEN);

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result register overwritten while a result is pending");

  a_attempt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && sts.go_attempt) |=> !s_axis_tready_o)
    else $error("input taken while an attempt is in progress");

  a_legal_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (legal_left <= MaxLenC))
    else $error("legal count exceeds the maximum length");

endmodule

// ===== design/upmx_ctrl.sv =====
// Controller state machine for the uniform PMX crossover block.
// Sequences the datapath steps and owns both stream handshakes; uses upmx_pkg.
module upmx_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  upmx_pkg::upmx_sts_t sts_i,
  output upmx_pkg::upmx_cmd_t cmd_o
);
  import upmx_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_D0   = 4'd1;
  localparam logic [3:0] S_D1   = 4'd2;
  localparam logic [3:0] S_D2   = 4'd3;
  localparam logic [3:0] S_D3   = 4'd4;
  localparam logic [3:0] S_C0   = 4'd5;
  localparam logic [3:0] S_C1   = 4'd6;
  localparam logic [3:0] S_C2   = 4'd7;
  localparam logic [3:0] S_C3   = 4'd8;
  localparam logic [3:0] S_C4   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_q, state_d;
  logic       pass_q, pass_d;
  logic       out_valid_q, out_valid_d;
  logic       emit;

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;
  assign emit      = (state_q == S_DONE) && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    cmd_o.op   = OP_IDLE;
    cmd_o.emit = emit;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          pass_d   = 1'b0;
          state_d  = sts_i.go_attempt ? S_D0 : S_DONE;
        end
      end
      S_D0: begin
        cmd_o.op = OP_D0;
        state_d  = S_D1;
      end
      S_D1: begin
        cmd_o.op = OP_D1;
        state_d  = S_D2;
      end
      S_D2: begin
        cmd_o.op = OP_D2;
        state_d  = S_D3;
      end
      S_D3: begin
        cmd_o.op = OP_D3;
        state_d  = pass_q ? S_DONE : S_C0;
      end
      S_C0: begin
        cmd_o.op = OP_C0;
        state_d  = S_C1;
      end
      S_C1: begin
        cmd_o.op = OP_C1;
        state_d  = S_C2;
      end
      S_C2: begin
        cmd_o.op = OP_C2;
        state_d  = S_C3;
      end
      S_C3: begin
        cmd_o.op = OP_C3;
        state_d  = S_C4;
      end
      S_C4: begin
        cmd_o.op = OP_C4;
        if (sts_i.redrop) begin
          pass_d  = 1'b1;
          state_d = S_D0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/upmx_dp.sv =====
// Datapath for the uniform PMX crossover block: the four position memories,
// the legal and attempt counters, the length register and the result register.
// Driven by upmx_ctrl through upmx_pkg command and status structs.
module upmx_dp #(
  parameter int MAX_LEN = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [upmx_pkg::CNT_W-1:0]  cfg_data_i,
  input  upmx_pkg::upmx_cmd_t         cmd_i,
  output upmx_pkg::upmx_sts_t         sts_o,
  input  logic [upmx_pkg::REQ_W-1:0]  req_type_i,
  input  logic [upmx_pkg::SLOT_W-1:0] position_i,
  input  logic [upmx_pkg::SLOT_W-1:0] parent1_value_i,
  input  logic [upmx_pkg::SLOT_W-1:0] parent2_value_i,
  input  logic [upmx_pkg::SLOT_W-1:0] random_draw_i,
  output logic [upmx_pkg::STAT_W-1:0] status_o,
  output logic [upmx_pkg::SLOT_W-1:0] child_value_o,
  output logic [upmx_pkg::CNT_W-1:0]  legal_left_o,
  output logic [upmx_pkg::ATT_W-1:0]  attempts_left_o
);
  import upmx_pkg::*;

  localparam logic [CNT_W-1:0] MaxLenC = CNT_W'(MAX_LEN);
  localparam int               LIM_W   = 13;

  logic [CNT_W-1:0]  perm_len_q, cnt_q, eff_len;
  logic [ATT_W-1:0]  att_q, limit, att_rem;
  logic [LIM_W-1:0]  lim_prod;
  logic [STAT_W-1:0] in_status, status_q;
  logic              in_ok, capture, load_ok, cval_en_q;
  logic [SLOT_W-1:0] idx_q, last_q, last_d, p1_q, p2_q, cv1_q;

  logic [SLOT_W-1:0] c_mem [SLOTS];
  logic [SLOT_W-1:0] p_mem [SLOTS];
  logic [SLOT_W-1:0] l_mem [SLOTS];
  logic [SLOT_W-1:0] q_mem [SLOTS];

  logic              c_we, c_re, p_we, p_re, l_we, l_re, q_we, q_re_a, q_re_b;
  logic [SLOT_W-1:0] c_wa, c_wd, c_ra, p_wa, p_wd, p_ra;
  logic [SLOT_W-1:0] l_wa, l_wd, l_ra_a, l_ra_b, q_wa, q_wd, q_ra_a, q_ra_b;
  logic [SLOT_W-1:0] c_rd_q, p_rd_q, l_a_q, l_b_q, q_a_q, q_b_q;

  logic [STAT_W-1:0] out_status_q;
  logic [SLOT_W-1:0] out_child_q;
  logic [CNT_W-1:0]  out_legal_q;
  logic [ATT_W-1:0]  out_att_q;

  assign eff_len  = (perm_len_q > MaxLenC) ? MaxLenC : perm_len_q;
  assign lim_prod = LIM_W'(eff_len) * LIM_W'(DIV3_MUL);
  assign limit    = ATT_W'(lim_prod >> DIV3_SHIFT);
  assign att_rem  = (att_q >= limit) ? '0 : limit - att_q;
  assign last_d   = SLOT_W'(cnt_q - CNT_W'(1));

  always_comb begin
    case (req_type_i)
      REQ_LOAD, REQ_READ: begin
        in_status = ({1'b0, position_i} >= eff_len) ? ST_BAD_POS : ST_OK;
      end
      REQ_ATTEMPT: begin
        if (att_rem == '0) begin
          in_status = ST_EXHAUST;
        end else if ({1'b0, random_draw_i} >= cnt_q) begin
          in_status = ST_DRAW;
        end else begin
          in_status = ST_OK;
        end
      end
      default: begin
        in_status = ST_OK;
      end
    endcase
  end

  assign in_ok            = (in_status == ST_OK);
  assign capture          = (cmd_i.op == OP_CAPTURE);
  assign load_ok          = capture && (req_type_i == REQ_LOAD) && in_ok;
  assign sts_o.go_attempt = (req_type_i == REQ_ATTEMPT) && in_ok;
  assign sts_o.redrop     = ({1'b0, q_a_q} < cnt_q);

  // Memory port selection per datapath step. The D steps remove one entry from
  // the legal list; the C steps locate and swap the two child entries.
  always_comb begin
    c_we = 1'b0; c_re = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    p_we = 1'b0; p_re = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
    l_we = 1'b0; l_re = 1'b0; l_wa = '0; l_wd = '0; l_ra_a = '0; l_ra_b = '0;
    q_we = 1'b0; q_re_a = 1'b0; q_re_b = 1'b0; q_wa = '0; q_wd = '0;
    q_ra_a = '0; q_ra_b = '0;
    case (cmd_i.op)
      OP_CAPTURE: begin
        c_we = load_ok; c_wa = position_i;      c_wd = parent1_value_i;
        p_we = load_ok; p_wa = parent2_value_i; p_wd = position_i;
        l_we = load_ok; l_wa = position_i;      l_wd = position_i;
        q_we = load_ok; q_wa = position_i;      q_wd = position_i;
        c_re = 1'b1;    c_ra = position_i;
      end
      OP_D0: begin
        l_re = 1'b1; l_ra_a = idx_q; l_ra_b = last_d;
      end
      OP_D1: begin
        l_we   = 1'b1; l_wa   = last_q; l_wd = l_a_q;
        q_re_a = 1'b1; q_ra_a = l_b_q;
        q_re_b = 1'b1; q_ra_b = l_a_q;
      end
      OP_D2: begin
        l_we = 1'b1; l_wa = idx_q; l_wd = l_b_q;
        q_we = 1'b1; q_wa = l_b_q; q_wd = q_b_q;
      end
      OP_D3: begin
        q_we = 1'b1; q_wa = l_a_q; q_wd = q_a_q;
      end
      OP_C0: begin
        c_re = 1'b1; c_ra = p1_q;
      end
      OP_C1: begin
        p_re = 1'b1; p_ra = c_rd_q;
      end
      OP_C2: begin
        c_re   = 1'b1; c_ra   = p_rd_q;
        q_re_a = 1'b1; q_ra_a = p_rd_q;
      end
      OP_C3: begin
        c_we = 1'b1; c_wa = p1_q; c_wd = c_rd_q;
      end
      OP_C4: begin
        c_we = 1'b1; c_wa = p2_q; c_wd = cv1_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (c_we) c_mem[c_wa] <= c_wd;
    if (c_re) c_rd_q <= c_mem[c_ra];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) p_mem[p_wa] <= p_wd;
    if (p_re) p_rd_q <= p_mem[p_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) l_mem[l_wa] <= l_wd;
    if (l_re) begin
      l_a_q <= l_mem[l_ra_a];
      l_b_q <= l_mem[l_ra_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re_a) q_a_q <= q_mem[q_ra_a];
    if (q_re_b) q_b_q <= q_mem[q_ra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_len_q <= PERM_LEN_RST;
      cnt_q      <= '0;
      att_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        perm_len_q <= cfg_data_i;
      end
      if (load_ok) begin
        cnt_q <= eff_len;
        att_q <= '0;
      end else if (cmd_i.op == OP_D0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end else if (cmd_i.op == OP_C4) begin
        att_q <= att_q + ATT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        idx_q     <= random_draw_i;
        status_q  <= in_status;
        cval_en_q <= (req_type_i == REQ_READ) && in_ok;
      end
      OP_D0: last_q <= last_d;
      OP_D1: p1_q   <= l_a_q;
      OP_C1: cv1_q  <= c_rd_q;
      OP_C2: p2_q   <= p_rd_q;
      OP_C4: idx_q  <= q_a_q;
      default: begin
      end
    endcase
    if (cmd_i.emit) begin
      out_status_q <= status_q;
      out_child_q  <= cval_en_q ? c_rd_q : '0;
      out_legal_q  <= cnt_q;
      out_att_q    <= att_rem;
    end
  end

  assign status_o        = out_status_q;
  assign child_value_o   = out_child_q;
  assign legal_left_o    = out_legal_q;
  assign attempts_left_o = out_att_q;

endmodule
